// ----- rtl/core/appc_pkg.sv -----
// Package for the arm preset position controller.
// Holds mode and status codes, register indexes, reset values and shared structs.
// No dependencies.
package appc_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE     = 3'd0,
		MODE_TOP      = 3'd1,
		MODE_BOTTOM   = 3'd2,
		MODE_MIDDLE   = 3'd3,
		MODE_MAN_UP   = 3'd4,
		MODE_MAN_DOWN = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_PROGRESS = 2'd0,
		ST_SUCCESS  = 2'd1,
		ST_FAILURE  = 2'd2,
		ST_ABORTED  = 2'd3
	} status_t;

	localparam logic [2:0] REG_MIN_POSITION    = 3'd0;
	localparam logic [2:0] REG_MID_POSITION    = 3'd1;
	localparam logic [2:0] REG_MAX_POSITION    = 3'd2;
	localparam logic [2:0] REG_MID_DEADBAND    = 3'd3;
	localparam logic [2:0] REG_POWER_UP        = 3'd4;
	localparam logic [2:0] REG_POWER_RETAIN_UP = 3'd5;
	localparam logic [2:0] REG_POWER_DOWN      = 3'd6;
	localparam logic [2:0] REG_TIMEOUT_TICKS   = 3'd7;

	localparam logic [11:0]        RST_MIN_POSITION    = 12'd280;
	localparam logic [11:0]        RST_MID_POSITION    = 12'd621;
	localparam logic [11:0]        RST_MAX_POSITION    = 12'd530;
	localparam logic [11:0]        RST_MID_DEADBAND    = 12'd10;
	localparam logic signed [15:0] RST_POWER_UP        = 16'sd9830;
	localparam logic signed [15:0] RST_POWER_RETAIN_UP = 16'sd3277;
	localparam logic signed [15:0] RST_POWER_DOWN      = -16'sd4915;
	localparam logic [15:0]        RST_TIMEOUT_TICKS   = 16'd75;

	localparam logic signed [15:0] MID_POWER_UP   = 16'sd6554;
	localparam logic signed [15:0] MID_POWER_DOWN = -16'sd4915;
	localparam logic signed [16:0] SETTLE_TICKS   = 17'sd100;

	typedef struct packed {
		logic [11:0]        min_position;
		logic [11:0]        mid_position;
		logic [11:0]        max_position;
		logic [11:0]        mid_deadband;
		logic signed [15:0] power_up;
		logic signed [15:0] power_retain_up;
		logic signed [15:0] power_down;
		logic [15:0]        timeout_ticks;
	} cfg_t;

	typedef struct packed {
		mode_t              cur_mode;
		mode_t              prev_mode;
		logic signed [16:0] tick_cnt;
		logic               pulse_phase;
	} state_t;

	typedef struct packed {
		logic signed [15:0] duty;
		status_t            status;
		mode_t              mode_after;
		logic               roller_state_written;
		logic               roller_sucking;
		logic               roller_power_written;
		logic               roller_power_reduced;
	} result_t;

endpackage

// ----- rtl/core/appc_cfg_regs.sv -----
// Configuration register file for the arm preset position controller.
// Depends on appc_pkg for register indexes, reset values and cfg_t.
module appc_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output appc_pkg::cfg_t    cfg
);

	appc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_position    <= appc_pkg::RST_MIN_POSITION;
			cfg_q.mid_position    <= appc_pkg::RST_MID_POSITION;
			cfg_q.max_position    <= appc_pkg::RST_MAX_POSITION;
			cfg_q.mid_deadband    <= appc_pkg::RST_MID_DEADBAND;
			cfg_q.power_up        <= appc_pkg::RST_POWER_UP;
			cfg_q.power_retain_up <= appc_pkg::RST_POWER_RETAIN_UP;
			cfg_q.power_down      <= appc_pkg::RST_POWER_DOWN;
			cfg_q.timeout_ticks   <= appc_pkg::RST_TIMEOUT_TICKS;
		end else if (cfg_write) begin
			case (cfg_index)
				appc_pkg::REG_MIN_POSITION:    cfg_q.min_position    <= cfg_data[11:0];
				appc_pkg::REG_MID_POSITION:    cfg_q.mid_position    <= cfg_data[11:0];
				appc_pkg::REG_MAX_POSITION:    cfg_q.max_position    <= cfg_data[11:0];
				appc_pkg::REG_MID_DEADBAND:    cfg_q.mid_deadband    <= cfg_data[11:0];
				appc_pkg::REG_POWER_UP:        cfg_q.power_up        <= cfg_data;
				appc_pkg::REG_POWER_RETAIN_UP: cfg_q.power_retain_up <= cfg_data;
				appc_pkg::REG_POWER_DOWN:      cfg_q.power_down      <= cfg_data;
				appc_pkg::REG_TIMEOUT_TICKS:   cfg_q.timeout_ticks   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/appc_step.sv -----
// One control tick of the arm preset position controller: mode select,
// timeout counting, position compares and roller commands, all combinational.
// Depends on appc_pkg for cfg_t, state_t, result_t and the mode codes.
module appc_step (
	input  appc_pkg::cfg_t    cfg,
	input  appc_pkg::state_t  state,
	input  logic              abort,
	input  logic              mode_write,
	input  logic [2:0]        func,
	input  logic [11:0]       pot_value,
	output appc_pkg::state_t  state_next,
	output appc_pkg::result_t res
);

	appc_pkg::mode_t    mode_sel;
	logic signed [16:0] cnt_load;
	logic signed [16:0] cnt_dec;
	logic               expired;
	logic [12:0]        mid_hi;
	logic signed [13:0] mid_lo;
	logic signed [13:0] pot_s;

	always_comb begin
		// unknown mode codes leave the stored mode alone
		if (mode_write && func <= appc_pkg::MODE_MAN_DOWN)
			mode_sel = appc_pkg::mode_t'(func);
		else
			mode_sel = state.cur_mode;

		cnt_load = (state.prev_mode != mode_sel) ? $signed({1'b0, cfg.timeout_ticks})
			: state.tick_cnt;
		// saturate at -1
		cnt_dec = cnt_load[16] ? cnt_load : cnt_load - 17'sd1;
		expired = cnt_dec[16];

		mid_hi = {1'b0, cfg.mid_position} + {1'b0, cfg.mid_deadband};
		mid_lo = $signed({2'b00, cfg.mid_position}) - $signed({2'b00, cfg.mid_deadband});
		pot_s  = $signed({2'b00, pot_value});
	end

	always_comb begin
		state_next = state;
		res.duty = 16'sd0;
		res.status = appc_pkg::ST_PROGRESS;
		res.mode_after = mode_sel;
		res.roller_state_written = 1'b0;
		res.roller_sucking = 1'b0;
		res.roller_power_written = 1'b0;
		res.roller_power_reduced = 1'b0;

		if (abort) begin
			// keep previous mode and counter
			state_next.cur_mode = appc_pkg::MODE_IDLE;
			res.mode_after = appc_pkg::MODE_IDLE;
			res.status = appc_pkg::ST_ABORTED;
		end else begin
			state_next.tick_cnt = cnt_load;
			case (mode_sel)
				appc_pkg::MODE_TOP: begin
					res.roller_power_written = 1'b1;
					state_next.tick_cnt = cnt_dec;
					if (expired) begin
						res.status = appc_pkg::ST_FAILURE;
					end else if (pot_value >= cfg.max_position) begin
						res.status = appc_pkg::ST_SUCCESS;
						res.duty = cfg.power_retain_up;
						state_next.tick_cnt = appc_pkg::SETTLE_TICKS;
					end else begin
						res.duty = cfg.power_up;
						res.roller_power_reduced = 1'b1;
						res.roller_state_written = 1'b1;
						state_next.pulse_phase = ~state.pulse_phase;
						// suck when the toggled phase lands on zero
						res.roller_sucking = state.pulse_phase;
					end
				end
				appc_pkg::MODE_BOTTOM: begin
					res.roller_power_written = 1'b1;
					state_next.tick_cnt = cnt_dec;
					if (expired) begin
						res.status = appc_pkg::ST_FAILURE;
					end else if (pot_value <= cfg.min_position) begin
						res.status = appc_pkg::ST_SUCCESS;
						state_next.tick_cnt = appc_pkg::SETTLE_TICKS;
					end else begin
						res.duty = cfg.power_down;
					end
				end
				appc_pkg::MODE_MIDDLE: begin
					if ({1'b0, pot_value} > mid_hi) begin
						res.duty = appc_pkg::MID_POWER_DOWN;
					end else if (pot_s < mid_lo) begin
						res.duty = appc_pkg::MID_POWER_UP;
					end else begin
						res.status = appc_pkg::ST_SUCCESS;
						state_next.tick_cnt = appc_pkg::SETTLE_TICKS;
					end
				end
				appc_pkg::MODE_MAN_UP: begin
					if (pot_value < cfg.max_position)
						res.duty = cfg.power_up;
					res.mode_after = appc_pkg::MODE_IDLE;
				end
				appc_pkg::MODE_MAN_DOWN: begin
					if (pot_value > cfg.min_position)
						res.duty = cfg.power_down;
					res.mode_after = appc_pkg::MODE_IDLE;
				end
				default: begin
					res.status = appc_pkg::ST_SUCCESS;
				end
			endcase
			state_next.cur_mode = res.mode_after;
			state_next.prev_mode = res.mode_after;
		end
	end

endmodule

// ----- rtl/core/arm_preset_position_controller_top.sv -----
// Arm preset position controller, top level.
// A request taken into the input register is then loaded into the result register;
// one request per cycle sustained while out_stall is low.
// The state update and the result register load happen in the same cycle.
// Reset: configuration returns to defaults, mode idle, counter and phase zero.
// Depends on appc_pkg, appc_cfg_regs and appc_step.
module arm_preset_position_controller_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               abort,
	input  logic               mode_write,
	input  logic [2:0]         func,
	input  logic [11:0]        pot_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] duty,
	output logic [1:0]         status,
	output logic [2:0]         mode_after,
	output logic               roller_state_written,
	output logic               roller_sucking,
	output logic               roller_power_written,
	output logic               roller_power_reduced
);

	appc_pkg::cfg_t    cfg;
	appc_pkg::state_t  state_q;
	appc_pkg::state_t  state_next;
	appc_pkg::result_t res;
	appc_pkg::result_t res_q;

	logic        valid_s1;
	logic        abort_s1;
	logic        mode_write_s1;
	logic [2:0]  func_s1;
	logic [11:0] pot_value_s1;
	logic        out_valid_q;
	logic        out_free;
	logic        advance;
	logic        in_take;

	appc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	appc_step u_step (
		.cfg        (cfg),
		.state      (state_q),
		.abort      (abort_s1),
		.mode_write (mode_write_s1),
		.func       (func_s1),
		.pot_value  (pot_value_s1),
		.state_next (state_next),
		.res        (res)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			abort_s1      <= abort;
			mode_write_s1 <= mode_write;
			func_s1       <= func;
			pot_value_s1  <= pot_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cur_mode    <= appc_pkg::MODE_IDLE;
			state_q.prev_mode   <= appc_pkg::MODE_IDLE;
			state_q.tick_cnt    <= 17'sd0;
			state_q.pulse_phase <= 1'b0;
			out_valid_q         <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_next;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign out_valid            = out_valid_q;
	assign duty                 = res_q.duty;
	assign status               = res_q.status;
	assign mode_after           = res_q.mode_after;
	assign roller_state_written = res_q.roller_state_written;
	assign roller_sucking       = res_q.roller_sucking;
	assign roller_power_written = res_q.roller_power_written;
	assign roller_power_reduced = res_q.roller_power_reduced;

endmodule
